// File: hw/rtl/histogram_range_colouring_assert.svh
// ----------------------------------------------------------------------------
// Histogram range colouring assertion macros
// Concurrent check macros used by the colouring datapath; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_RANGE_COLOURING_ASSERT_SVH
`define HISTOGRAM_RANGE_COLOURING_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define HRC_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram colouring check violated");
// next-cycle implication
`define HRC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram colouring check violated");
`else
`define HRC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define HRC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/hrc_pkg.sv
// ----------------------------------------------------------------------------
// Histogram range colouring package
// Field widths, operation and register codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int ITER_W     = 11;
  localparam int CHAN_W     = 8;
  localparam int COLOUR_W   = 3 * CHAN_W;
  localparam int RC_W       = 2;
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = COLOUR_W;
  localparam int MAX_RANGES = 3;
  localparam int NUM_CHANS  = 3;
  localparam int STEP_W     = $clog2(CHAN_W);

  localparam logic [RC_W-1:0]   RANGE_COUNT_RESET = 2'd1;
  localparam logic [ITER_W-1:0] BOUND_RESET       = 11'd1024;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_COLOUR = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_RANGE_COUNT  = 3'd0,
    REG_BOUND_ONE    = 3'd1,
    REG_BOUND_TWO    = 3'd2,
    REG_BOUND_THREE  = 3'd3,
    REG_COLOUR_ZERO  = 3'd4,
    REG_COLOUR_ONE   = 3'd5,
    REG_COLOUR_TWO   = 3'd6,
    REG_COLOUR_THREE = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic take;
    logic clr_run;
    logic add_rd;
    logic add_wr;
    logic find;
    logic walk_run;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic black;
    logic walk_done;
    logic div_last;
    logic chan_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/hrc_if.sv
// ----------------------------------------------------------------------------
// Histogram range colouring channels
// Valid/ready interfaces for pixel words in and colour words out.
// ----------------------------------------------------------------------------
interface hrc_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [hrc_pkg::ITER_W-1:0]  iterations;

  modport source (output valid, output op, output iterations, input ready);
  modport sink   (input valid, input op, input iterations, output ready);
endinterface

interface hrc_colour_if;
  logic                        valid;
  logic                        ready;
  logic [hrc_pkg::CHAN_W-1:0]  red;
  logic [hrc_pkg::CHAN_W-1:0]  green;
  logic [hrc_pkg::CHAN_W-1:0]  blue;
  logic                        coloured;

  modport source (output valid, output red, output green, output blue,
                  output coloured, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input coloured, output ready);
endinterface

// File: hw/rtl/hrc_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram range colouring controller
// Sequences clear sweeps, bin updates, range walks and the channel divider.
// ----------------------------------------------------------------------------
module hrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  logic [1:0]          op,
  output logic                ready,
  output hrc_pkg::dp_cmd_t    cmd,
  input  hrc_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_FIND,
    S_WALK,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    ready      = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
        if (valid) begin
          cmd.take = 1'b1;
          case (op)
            hrc_pkg::OP_ADD:    state_next = S_ADD_RD;
            hrc_pkg::OP_COLOUR: state_next = S_FIND;
            hrc_pkg::OP_CLEAR:  state_next = S_CLEAR;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = status.black ? S_OUT : S_WALK;
      end
      S_WALK: begin
        cmd.walk_run = 1'b1;
        if (status.walk_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = status.chan_last ? S_OUT : S_MUL;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/hrc_datapath.sv
// ----------------------------------------------------------------------------
// Histogram range colouring datapath
// Bin memory, config registers, range walk, channel divider, result register.
// ----------------------------------------------------------------------------
`include "histogram_range_colouring_assert.svh"

module hrc_datapath #(
  parameter int MAX_ITER   = 1024,
  parameter int COUNT_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hrc_pkg::dp_cmd_t                   cmd,
  output hrc_pkg::dp_status_t                status,
  input  logic [hrc_pkg::ITER_W-1:0]         iterations,
  input  logic                               wr_en,
  input  logic [hrc_pkg::CFG_IW-1:0]         wr_index,
  input  logic [hrc_pkg::CFG_DW-1:0]         wr_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [hrc_pkg::CHAN_W-1:0]         red,
  output logic [hrc_pkg::CHAN_W-1:0]         green,
  output logic [hrc_pkg::CHAN_W-1:0]         blue,
  output logic                               coloured
);

  localparam int AW = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
  localparam int IW = (AW >= hrc_pkg::ITER_W) ? AW + 1 : hrc_pkg::ITER_W + 1;
  localparam int PW = COUNT_BITS + hrc_pkg::CHAN_W;
  localparam int RW = PW + 1;
  localparam int DW = COUNT_BITS + hrc_pkg::CHAN_W - 1;
  localparam logic [IW-1:0] MAX_IDX   = IW'(MAX_ITER);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ITER - 1);

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] x,
                                                    input logic [COUNT_BITS-1:0] y);
    logic [COUNT_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  // configuration registers
  logic [hrc_pkg::RC_W-1:0]     range_count;
  logic [hrc_pkg::ITER_W-1:0]   bound_regs [1:3];
  logic [hrc_pkg::COLOUR_W-1:0] colours    [0:3];
  logic [hrc_pkg::ITER_W-1:0]   limits     [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= hrc_pkg::RANGE_COUNT_RESET;
      for (int i = 1; i <= 3; i++) begin
        bound_regs[i] <= hrc_pkg::BOUND_RESET;
      end
      for (int i = 0; i <= 3; i++) begin
        colours[i] <= '0;
      end
    end else if (wr_en) begin
      case (wr_index)
        hrc_pkg::REG_RANGE_COUNT:  range_count   <= wr_data[hrc_pkg::RC_W-1:0];
        hrc_pkg::REG_BOUND_ONE:    bound_regs[1] <= wr_data[hrc_pkg::ITER_W-1:0];
        hrc_pkg::REG_BOUND_TWO:    bound_regs[2] <= wr_data[hrc_pkg::ITER_W-1:0];
        hrc_pkg::REG_BOUND_THREE:  bound_regs[3] <= wr_data[hrc_pkg::ITER_W-1:0];
        hrc_pkg::REG_COLOUR_ZERO:  colours[0]    <= wr_data;
        hrc_pkg::REG_COLOUR_ONE:   colours[1]    <= wr_data;
        hrc_pkg::REG_COLOUR_TWO:   colours[2]    <= wr_data;
        hrc_pkg::REG_COLOUR_THREE: colours[3]    <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    limits[0] = '0;
    for (int i = 1; i <= 3; i++) begin
      limits[i] = bound_regs[i];
    end
  end

  // latched iteration count
  logic [hrc_pkg::ITER_W-1:0] it_reg;
  logic [IW-1:0]              it_ext;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_reg <= iterations;
    end
  end

  assign it_ext = IW'(it_reg);

  // range search: first range in use whose end lies above the count
  logic [hrc_pkg::RC_W-1:0]   used;
  logic                       found;
  logic                       black;
  logic [1:0]                 r_sel;
  logic [1:0]                 r_end;
  logic [IW-1:0]              hi_raw;
  logic [IW-1:0]              hi_sel;

  always_comb begin
    used  = (range_count > hrc_pkg::RC_W'(hrc_pkg::MAX_RANGES)) ?
            hrc_pkg::RC_W'(hrc_pkg::MAX_RANGES) : range_count;
    found = 1'b0;
    r_sel = '0;
    for (int k = hrc_pkg::MAX_RANGES - 1; k >= 0; k--) begin
      if ((k < int'(used)) && (it_reg < limits[k + 1])) begin
        found = 1'b1;
        r_sel = 2'(k);
      end
    end
    black  = (it_ext >= MAX_IDX) || !found;
    r_end  = 2'(r_sel + 2'd1);
    hi_raw = IW'(limits[r_end]);
    hi_sel = (hi_raw > MAX_IDX) ? MAX_IDX : hi_raw;
  end

  // bin memory and walk
  logic [COUNT_BITS-1:0] mem [MAX_ITER];
  logic [COUNT_BITS-1:0] rdata;
  logic [AW-1:0]         clr_idx;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_val;
  logic                  wr_we;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         hi_reg;
  logic                  issue;
  logic                  p_vld;
  logic                  p_inc;
  logic [COUNT_BITS-1:0] tot_acc;
  logic [COUNT_BITS-1:0] cnt_acc;

  assign issue = idx < hi_reg;

  always_comb begin
    rd_addr = cmd.add_rd ? it_ext[AW-1:0] : idx[AW-1:0];
    wr_we   = cmd.clr_run || (cmd.add_wr && (it_ext < MAX_IDX));
    wr_addr = cmd.clr_run ? clr_idx : it_ext[AW-1:0];
    wr_val  = cmd.clr_run ? '0 : sat_add(rdata, COUNT_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (wr_we) begin
      mem[wr_addr] <= wr_val;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_run) begin
      clr_idx <= (clr_idx == LAST_ADDR) ? '0 : clr_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld   <= 1'b0;
      tot_acc <= '0;
      cnt_acc <= '0;
    end else if (cmd.find) begin
      p_vld   <= 1'b0;
      tot_acc <= '0;
      cnt_acc <= '0;
    end else if (cmd.walk_run) begin
      p_vld <= issue;
      if (p_vld) begin
        tot_acc <= sat_add(tot_acc, rdata);
        if (p_inc) begin
          cnt_acc <= sat_add(cnt_acc, rdata);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      idx    <= IW'(limits[r_sel]);
      hi_reg <= hi_sel;
    end else if (cmd.walk_run) begin
      p_inc <= idx <= it_ext;
      if (issue) begin
        idx <= idx + IW'(1);
      end
    end
  end

  // channel blend: multiply, then restoring divide one quotient bit a cycle
  logic [hrc_pkg::COLOUR_W-1:0] col_a;
  logic [hrc_pkg::COLOUR_W-1:0] col_b;
  logic [1:0]                   ch;
  logic [hrc_pkg::CHAN_W-1:0]   a_ch;
  logic [hrc_pkg::CHAN_W-1:0]   b_ch;
  logic                         down_c;
  logic [hrc_pkg::CHAN_W-1:0]   diff;
  logic [PW-1:0]                prod;
  logic                         down_reg;
  logic [RW-1:0]                rem;
  logic [RW-1:0]                rem_nx;
  logic [DW-1:0]                dv;
  logic                         ge;
  logic [hrc_pkg::CHAN_W-1:0]   q;
  logic [hrc_pkg::CHAN_W-1:0]   q_nx;
  logic [hrc_pkg::STEP_W-1:0]   step;
  logic [hrc_pkg::CHAN_W-1:0]   chan_val;
  logic [hrc_pkg::CHAN_W-1:0]   res_red;
  logic [hrc_pkg::CHAN_W-1:0]   res_green;
  logic [hrc_pkg::CHAN_W-1:0]   res_blue;
  logic                         res_col;

  always_comb begin
    case (ch)
      2'd0: begin
        a_ch = col_a[23:16];
        b_ch = col_b[23:16];
      end
      2'd1: begin
        a_ch = col_a[15:8];
        b_ch = col_b[15:8];
      end
      default: begin
        a_ch = col_a[7:0];
        b_ch = col_b[7:0];
      end
    endcase
    down_c   = b_ch < a_ch;
    diff     = down_c ? a_ch - b_ch : b_ch - a_ch;
    ge       = rem >= RW'(dv);
    rem_nx   = ge ? rem - RW'(dv) : rem;
    q_nx     = {q[hrc_pkg::CHAN_W-2:0], ge};
    chan_val = (tot_acc == '0) ? a_ch : (down_reg ? a_ch - q_nx : a_ch + q_nx);
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      col_a     <= colours[r_sel];
      col_b     <= colours[r_end];
      res_red   <= '0;
      res_green <= '0;
      res_blue  <= '0;
      res_col   <= !black;
    end
    if (cmd.mul) begin
      prod     <= PW'(diff) * PW'(cnt_acc);
      down_reg <= down_c;
    end
    if (cmd.div_init) begin
      rem  <= down_reg ? RW'(prod) + RW'(tot_acc) - RW'(1) : RW'(prod);
      dv   <= DW'(tot_acc) << (hrc_pkg::CHAN_W - 1);
      q    <= '0;
      step <= hrc_pkg::STEP_W'(hrc_pkg::CHAN_W - 1);
    end
    if (cmd.div_step) begin
      rem  <= rem_nx;
      q    <= q_nx;
      dv   <= dv >> 1;
      step <= step - hrc_pkg::STEP_W'(1);
      if (step == '0) begin
        case (ch)
          2'd0:    res_red   <= chan_val;
          2'd1:    res_green <= chan_val;
          default: res_blue  <= chan_val;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.find) begin
      ch <= '0;
    end else if (cmd.div_step && (step == '0)) begin
      ch <= ch + 2'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red      <= res_red;
      green    <= res_green;
      blue     <= res_blue;
      coloured <= res_col;
    end
  end

  always_comb begin
    status.clr_last  = clr_idx == LAST_ADDR;
    status.black     = black;
    status.walk_done = !issue && !p_vld;
    status.div_last  = step == '0;
    status.chan_last = ch == 2'(hrc_pkg::NUM_CHANS - 1);
    status.out_free  = !res_valid || res_ready;
  end

  `HRC_ASSERT_IMPL(a_partial_le_total, clk, rst, cmd.walk_run, cnt_acc <= tot_acc)
  `HRC_ASSERT_IMPL(a_walk_in_memory, clk, rst, cmd.walk_run && issue, idx < MAX_IDX)
  `HRC_ASSERT_IMPL(a_div_rem_bound, clk, rst, cmd.div_step && (tot_acc != '0), rem < (RW'(dv) << 1))
  `HRC_ASSERT_IMPL(a_add_after_read, clk, rst, cmd.add_wr, $past(cmd.add_rd))

endmodule

// File: hw/rtl/histogram_range_colouring.sv
// ----------------------------------------------------------------------------
// Histogram range colouring
// Histogram-equalized colour lookup for escape-time iteration counts.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  - input words {op, iterations}: add counts a pixel into its bin,
//            clear empties the histogram, colour returns one colour word.
//   colour - output words {red, green, blue, coloured}, one per colour word.
//   wr_*   - register writes, taken on any cycle with wr_en high; write them
//            only while the block is idle.
// Operation sequences, from acceptance to the next acceptance:
//   add    read the bin, add one with saturation, write it back
//   clear  one bin zeroed per cycle
//   colour the walk reads one bin a cycle through the memory read port, then
//          each channel takes a multiply and a bitwise divide. A black
//          pixel skips the walk and the divide and goes straight to output.
// Reset: the histogram is swept to zero; pixel.ready stays low until the
//   sweep ends. Registers take their reset values.
// Stall: the colour word waits in an output register; the block keeps
//   taking pixel words and holds only when a second colour word is ready.
// ----------------------------------------------------------------------------
module histogram_range_colouring #(
  parameter int MAX_ITER   = 1024,
  parameter int COUNT_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  hrc_pixel_if.sink                  pixel,
  hrc_colour_if.source               colour,
  input  logic                       wr_en,
  input  logic [hrc_pkg::CFG_IW-1:0] wr_index,
  input  logic [hrc_pkg::CFG_DW-1:0] wr_data
);

  hrc_pkg::dp_cmd_t    cmd;
  hrc_pkg::dp_status_t status;

  // sequence each word: sweep, add, walk, divide, load result
  hrc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .valid  (pixel.valid),
    .op     (pixel.op),
    .ready  (pixel.ready),
    .cmd    (cmd),
    .status (status)
  );

  // histogram storage, range search, blend arithmetic and output register
  hrc_datapath #(
    .MAX_ITER   (MAX_ITER),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .iterations (pixel.iterations),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .res_valid  (colour.valid),
    .res_ready  (colour.ready),
    .red        (colour.red),
    .green      (colour.green),
    .blue       (colour.blue),
    .coloured   (colour.coloured)
  );

endmodule
